FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GRG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grg: implication check failed");

`define GRG_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("grg: invariant check failed");

`else

`define GRG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define GRG_ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

FILE: sv/grg_pkg.sv
// ----------------------------------------------------------------------------
// grg_pkg
// Types, constants and the 1-3-3-1 tap combiner for the gray reduce core.
// ----------------------------------------------------------------------------
package grg_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int CNT_W       = 12;
    localparam int HSUM_W      = 11;
    localparam int CIDX_W      = 11;
    localparam int VSUM_W      = 15;
    localparam int PIX_W       = 8;
    localparam int ROW_W       = 11;
    localparam int COL_W       = 10;
    localparam int LINE_W      = 3 * HSUM_W;

    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SRC_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] SRC_HEIGHT_RESET = 12'd480;
    localparam logic [CFG_DATA_W-1:0] SRC_WIDTH_MIN    = 12'd3;
    localparam logic [CFG_DATA_W-1:0] SRC_HEIGHT_MIN   = 12'd2;

    localparam logic [VSUM_W-1:0] ROUND_BIAS = 15'd32;
    localparam int                ROUND_SHIFT = 6;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_FULL   = 2'd0;
    localparam kind_t KIND_DOUBLE = 2'd1;
    localparam kind_t KIND_TRIPLE = 2'd2;

    typedef logic [HSUM_W-1:0] hsum_t;
    typedef logic [VSUM_W-1:0] vsum_t;

    function automatic vsum_t combine(input hsum_t o2, input hsum_t o1, input hsum_t o0,
                                      input hsum_t cur, input kind_t kind);
        vsum_t e2;
        vsum_t e1;
        vsum_t e0;
        vsum_t ec;
        vsum_t res;
        e2 = {4'b0, o2};
        e1 = {4'b0, o1};
        e0 = {4'b0, o0};
        ec = {4'b0, cur};
        case (kind)
            KIND_FULL:   res = e2 + (e1 + e0) * 15'd3 + ec;
            KIND_DOUBLE: res = e1 + e0 * 15'd3 + ec * 15'd4;
            default:     res = e0 + ec * 15'd7;
        endcase
        return res;
    endfunction

endpackage

FILE: sv/gray_reduce_4x4_gaussian_core.sv
// ----------------------------------------------------------------------------
// gray_reduce_4x4_gaussian_core
// Halves a gray image in both directions with a separable 1-3-3-1 kernel.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on the s_ channel (valid/ready); each
// transaction carries one 8-bit pixel. Reduced pixels leave on the m_ channel,
// each with its destination row and column, and m_frame_last on the final one
// of the frame. src_width and src_height are written through the cfg_ channel;
// the user must write them only while the core is idle, which the core does not
// enforce; cfg_ready is always high. A result is formed from the line buffer
// read and stage 1 registers, then held in the output register until taken.
// Throughput: one pixel per cycle while m_ready is high and each pixel completes
// at most one result; a pixel that completes k results (k up to 4 at the right
// and bottom edges of odd sizes) occupies the output register until all k are taken.
// Horizontal sums of the last three rows live in two single-port-write line
// buffer banks split by destination column parity, read and written at most once per
// pixel each, so one pixel per cycle is set by that read-modify-write loop.
// Reset (aresetn, synchronous) restores 640 x 480 and restarts at pixel (0,0);
// line buffers are not cleared. A stall on m_ready holds the output register
// and the line buffer stage, and s_ready drops until space frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gray_reduce_4x4_gaussian_core #(
    parameter int MAX_SRC_WIDTH = 2048,
    parameter int MAX_DST_WIDTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [grg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [grg_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [grg_pkg::PIX_W-1:0]            s_pixel,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [grg_pkg::PIX_W-1:0]            m_out_value,
    output logic [grg_pkg::ROW_W-1:0]            m_out_row,
    output logic [grg_pkg::COL_W-1:0]            m_out_col,
    output logic                                 m_frame_last
);

    localparam int W_CAP      = (MAX_SRC_WIDTH > 4095) ? 4095 : MAX_SRC_WIDTH;
    localparam int BANK_DEPTH = (MAX_DST_WIDTH + 1) / 2;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // configuration
    logic [grg_pkg::CFG_DATA_W-1:0] src_width_reg;
    logic [grg_pkg::CFG_DATA_W-1:0] src_height_reg;

    // frame position and pixel window
    logic [grg_pkg::CNT_W-1:0] col_count_reg;
    logic [grg_pkg::CNT_W-1:0] row_count_reg;
    logic [grg_pkg::PIX_W-1:0] win_reg [3];

    // line buffer banks
    logic [grg_pkg::LINE_W-1:0] line_even_mem [BANK_DEPTH];
    logic [grg_pkg::LINE_W-1:0] line_odd_mem  [BANK_DEPTH];
    logic [grg_pkg::LINE_W-1:0] even_rd_reg;
    logic [grg_pkg::LINE_W-1:0] odd_rd_reg;

    // stage 1
    logic                         s1_valid_reg;
    logic                         s1_first_row_reg;
    logic [2:0]                   s1_nres_reg;
    logic                         s1_frame_reg;
    logic                         s1_cv_reg   [2];
    logic                         s1_ok_reg   [2];
    logic                         s1_odd_reg  [2];
    logic [BAW-1:0]               s1_addr_reg [2];
    grg_pkg::hsum_t               s1_hs_reg   [2];
    logic [grg_pkg::COL_W-1:0]    s1_col_reg  [2];
    logic [grg_pkg::ROW_W-1:0]    s1_row_reg  [2];
    grg_pkg::kind_t               s1_rkind_reg [2];

    // stage 2: result group
    logic                         s2_valid_reg;
    logic [2:0]                   s2_cnt_reg;
    logic [1:0]                   s2_idx_reg;
    logic                         s2_frame_reg;
    logic [grg_pkg::PIX_W-1:0]    s2_value_reg [4];
    logic [grg_pkg::ROW_W-1:0]    s2_row_reg   [4];
    logic [grg_pkg::COL_W-1:0]    s2_col_reg   [4];

    // stage 0 decode
    logic [grg_pkg::CNT_W-1:0]    w_eff, h_eff, wm1, hm1, x, y;
    logic                         ev_ca, ev_cb, ev_ra, ev_rb;
    logic [grg_pkg::CIDX_W-1:0]   ca, cb, c0, c1, ra, rb, r0, r1;
    grg_pkg::kind_t               kind_cb, kind_rb, kind0, kind1, rkind0, rkind1;
    logic                         cv0, cv1, rv0, rv1;
    logic                         ok0, ok1;
    logic [grg_pkg::CIDX_W-1:0]   half0, half1;
    logic [BAW-1:0]               addr0, addr1;
    grg_pkg::vsum_t               hsum0_full, hsum1_full;
    grg_pkg::hsum_t               hs0, hs1;
    logic [2:0]                   nc3, nr3, nres;
    logic                         frame_end;
    logic                         accept;

    // bank ports
    logic                         even_re, odd_re, even_we, odd_we;
    logic [BAW-1:0]               even_raddr, odd_raddr, even_waddr, odd_waddr;
    logic [grg_pkg::LINE_W-1:0]   even_wdata, odd_wdata;

    // stage 1 compute
    logic [grg_pkg::LINE_W-1:0]   line_val [2];
    logic [grg_pkg::LINE_W-1:0]   wdata    [2];
    grg_pkg::vsum_t               vsum     [2][2];
    logic [grg_pkg::PIX_W-1:0]    vals     [2][2];
    logic                         s1_fire;
    logic                         s2_last_take;
    logic                         s2_free;
    logic [2:0]                   s2_idx_ext;
    logic                         s2_last_slot;

    assign cfg_ready = 1'b1;

    // ---------------- stage 0: position decode and horizontal sums ----------
    always_comb begin
        if (src_width_reg < grg_pkg::SRC_WIDTH_MIN) begin
            w_eff = grg_pkg::SRC_WIDTH_MIN;
        end else if (src_width_reg > 12'(W_CAP)) begin
            w_eff = 12'(W_CAP);
        end else begin
            w_eff = src_width_reg;
        end
        h_eff = (src_height_reg < grg_pkg::SRC_HEIGHT_MIN) ? grg_pkg::SRC_HEIGHT_MIN
                                                           : src_height_reg;
        wm1 = w_eff - 12'd1;
        hm1 = h_eff - 12'd1;
        x   = (col_count_reg > wm1) ? wm1 : col_count_reg;
        y   = (row_count_reg > hm1) ? hm1 : row_count_reg;

        ev_ca   = !x[0] && (x >= 12'd2);
        ca      = x[11:1] - 11'd1;
        ev_cb   = (x == wm1);
        cb      = w_eff[0] ? w_eff[11:1] : w_eff[11:1] - 11'd1;
        kind_cb = w_eff[0] ? grg_pkg::KIND_TRIPLE : grg_pkg::KIND_DOUBLE;

        ev_ra   = !y[0] && (y >= 12'd2);
        ra      = y[11:1] - 11'd1;
        ev_rb   = (y == hm1);
        rb      = h_eff[0] ? h_eff[11:1] : h_eff[11:1] - 11'd1;
        kind_rb = h_eff[0] ? grg_pkg::KIND_TRIPLE : grg_pkg::KIND_DOUBLE;

        cv0   = ev_ca || ev_cb;
        cv1   = ev_ca && ev_cb;
        c0    = ev_ca ? ca : cb;
        c1    = cb;
        kind0 = ev_ca ? grg_pkg::KIND_FULL : kind_cb;
        kind1 = kind_cb;

        rv0    = ev_ra || ev_rb;
        rv1    = ev_ra && ev_rb;
        r0     = ev_ra ? ra : rb;
        r1     = rb;
        rkind0 = ev_ra ? grg_pkg::KIND_FULL : kind_rb;
        rkind1 = kind_rb;

        ok0   = (c0 < MAX_DST_WIDTH);
        ok1   = (c1 < MAX_DST_WIDTH);
        half0 = {1'b0, c0[10:1]};
        half1 = {1'b0, c1[10:1]};
        addr0 = half0[BAW-1:0];
        addr1 = half1[BAW-1:0];

        hsum0_full = grg_pkg::combine({3'b0, win_reg[2]}, {3'b0, win_reg[1]},
                                      {3'b0, win_reg[0]}, {3'b0, s_pixel}, kind0);
        hsum1_full = grg_pkg::combine({3'b0, win_reg[2]}, {3'b0, win_reg[1]},
                                      {3'b0, win_reg[0]}, {3'b0, s_pixel}, kind1);
        hs0 = hsum0_full[grg_pkg::HSUM_W-1:0];
        hs1 = hsum1_full[grg_pkg::HSUM_W-1:0];

        nc3       = {2'b0, cv0} + {2'b0, cv1};
        nr3       = {2'b0, rv0} + {2'b0, rv1};
        nres      = (y == 12'd0) ? 3'd0 : nc3 * nr3;
        frame_end = ev_cb && ev_rb;
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        even_re    = accept && ((cv0 && ok0 && !c0[0]) || (cv1 && ok1 && !c1[0]));
        odd_re     = accept && ((cv0 && ok0 && c0[0]) || (cv1 && ok1 && c1[0]));
        even_raddr = c0[0] ? addr1 : addr0;
        odd_raddr  = c0[0] ? addr0 : addr1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= grg_pkg::SRC_WIDTH_RESET;
            src_height_reg <= grg_pkg::SRC_HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                grg_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                grg_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            win_reg[0]    <= '0;
            win_reg[1]    <= '0;
            win_reg[2]    <= '0;
        end else if (accept) begin
            if (col_count_reg >= wm1) begin
                col_count_reg <= '0;
                row_count_reg <= (row_count_reg >= hm1) ? '0 : row_count_reg + 12'd1;
            end else begin
                col_count_reg <= col_count_reg + 12'd1;
            end
            if (x == 12'd0) begin
                win_reg[0] <= s_pixel;
                win_reg[1] <= s_pixel;
                win_reg[2] <= s_pixel;
            end else begin
                win_reg[0] <= s_pixel;
                win_reg[1] <= win_reg[0];
                win_reg[2] <= win_reg[1];
            end
        end
    end

    // ---------------- line buffer banks ----------------
    always_ff @(posedge aclk) begin
        if (even_re) begin
            even_rd_reg <= line_even_mem[even_raddr];
        end
        if (even_we) begin
            line_even_mem[even_waddr] <= even_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (odd_re) begin
            odd_rd_reg <= line_odd_mem[odd_raddr];
        end
        if (odd_we) begin
            line_odd_mem[odd_waddr] <= odd_wdata;
        end
    end

    // ---------------- stage 1: vertical sums and write-back ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_first_row_reg <= (y == 12'd0);
            s1_nres_reg      <= nres;
            s1_frame_reg     <= frame_end;
            s1_cv_reg[0]     <= cv0;
            s1_cv_reg[1]     <= cv1;
            s1_ok_reg[0]     <= ok0;
            s1_ok_reg[1]     <= ok1;
            s1_odd_reg[0]    <= c0[0];
            s1_odd_reg[1]    <= c1[0];
            s1_addr_reg[0]   <= addr0;
            s1_addr_reg[1]   <= addr1;
            s1_hs_reg[0]     <= hs0;
            s1_hs_reg[1]     <= hs1;
            s1_col_reg[0]    <= c0[grg_pkg::COL_W-1:0];
            s1_col_reg[1]    <= c1[grg_pkg::COL_W-1:0];
            s1_row_reg[0]    <= r0;
            s1_row_reg[1]    <= r1;
            s1_rkind_reg[0]  <= rkind0;
            s1_rkind_reg[1]  <= rkind1;
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            line_val[j] = s1_odd_reg[j] ? odd_rd_reg : even_rd_reg;
            if (!s1_ok_reg[j]) begin
                line_val[j] = '0;
            end
            wdata[j] = s1_first_row_reg ? {s1_hs_reg[j], s1_hs_reg[j], s1_hs_reg[j]}
                                        : {line_val[j][21:0], s1_hs_reg[j]};
            for (int i = 0; i < 2; i++) begin
                vsum[i][j] = grg_pkg::combine(line_val[j][32:22], line_val[j][21:11],
                                              line_val[j][10:0], s1_hs_reg[j],
                                              s1_rkind_reg[i]) + grg_pkg::ROUND_BIAS;
                vals[i][j] = vsum[i][j][grg_pkg::ROUND_SHIFT +: grg_pkg::PIX_W];
            end
        end
    end

    always_comb begin
        even_we    = s1_fire && ((s1_cv_reg[0] && s1_ok_reg[0] && !s1_odd_reg[0]) ||
                                 (s1_cv_reg[1] && s1_ok_reg[1] && !s1_odd_reg[1]));
        odd_we     = s1_fire && ((s1_cv_reg[0] && s1_ok_reg[0] && s1_odd_reg[0]) ||
                                 (s1_cv_reg[1] && s1_ok_reg[1] && s1_odd_reg[1]));
        even_waddr = s1_odd_reg[0] ? s1_addr_reg[1] : s1_addr_reg[0];
        odd_waddr  = s1_odd_reg[0] ? s1_addr_reg[0] : s1_addr_reg[1];
        even_wdata = s1_odd_reg[0] ? wdata[1] : wdata[0];
        odd_wdata  = s1_odd_reg[0] ? wdata[0] : wdata[1];
    end

    // ---------------- stage 2: result group and output ----------------
    assign s2_idx_ext   = {1'b0, s2_idx_reg};
    assign s2_last_slot = (s2_idx_ext == s2_cnt_reg - 3'd1);
    assign s2_last_take = s2_valid_reg && m_ready && s2_last_slot;
    assign s2_free      = !s2_valid_reg || s2_last_take;
    assign s1_fire      = s1_valid_reg && ((s1_nres_reg == 3'd0) || s2_free);
    assign s_ready      = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s2_cnt_reg   <= '0;
            s2_idx_reg   <= '0;
        end else if (s1_fire && (s1_nres_reg != 3'd0)) begin
            s2_valid_reg <= 1'b1;
            s2_cnt_reg   <= s1_nres_reg;
            s2_idx_reg   <= '0;
        end else if (s2_last_take) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_valid_reg && m_ready) begin
            s2_idx_reg <= s2_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && (s1_nres_reg != 3'd0)) begin
            s2_frame_reg    <= s1_frame_reg;
            s2_value_reg[0] <= vals[0][0];
            s2_row_reg[0]   <= s1_row_reg[0];
            s2_col_reg[0]   <= s1_col_reg[0];
            if (s1_cv_reg[1]) begin
                s2_value_reg[1] <= vals[0][1];
                s2_row_reg[1]   <= s1_row_reg[0];
                s2_col_reg[1]   <= s1_col_reg[1];
            end else begin
                s2_value_reg[1] <= vals[1][0];
                s2_row_reg[1]   <= s1_row_reg[1];
                s2_col_reg[1]   <= s1_col_reg[0];
            end
            s2_value_reg[2] <= vals[1][0];
            s2_row_reg[2]   <= s1_row_reg[1];
            s2_col_reg[2]   <= s1_col_reg[0];
            s2_value_reg[3] <= vals[1][1];
            s2_row_reg[3]   <= s1_row_reg[1];
            s2_col_reg[3]   <= s1_col_reg[1];
        end
    end

    assign m_valid      = s2_valid_reg;
    assign m_out_value  = s2_value_reg[s2_idx_reg];
    assign m_out_row    = s2_row_reg[s2_idx_reg];
    assign m_out_col    = s2_col_reg[s2_idx_reg];
    assign m_frame_last = s2_frame_reg && s2_last_slot;

    // ---------------- assertions ----------------
    `GRG_ASSERT_IMPLY(a_even_bank_no_clash, aclk, aresetn, even_re && even_we, even_raddr != even_waddr)
    `GRG_ASSERT_IMPLY(a_odd_bank_no_clash, aclk, aresetn, odd_re && odd_we, odd_raddr != odd_waddr)
    `GRG_ASSERT_IMPLY(a_group_slot_in_range, aclk, aresetn, s2_valid_reg, (s2_cnt_reg != 3'd0) && (s2_idx_ext < s2_cnt_reg))
    `GRG_ASSERT_ALWAYS(a_no_accept_over_full, aclk, aresetn, !(accept && s1_valid_reg && !s1_fire))

endmodule

FILE: tb/gray_reduce_4x4_gaussian_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gray_reduce_4x4_gaussian_checker
// Watches the core's configuration, pixel and result channels, keeps its own
// model of the 1-3-3-1 reduce (line buffers, pixel window, frame position) and
// checks every result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gray_reduce_4x4_gaussian_checker #(
    parameter int MAX_SRC_WIDTH = 2048,
    parameter int MAX_DST_WIDTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [grg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [grg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [grg_pkg::PIX_W-1:0]       s_pixel,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [grg_pkg::PIX_W-1:0]       m_out_value,
    input  logic [grg_pkg::ROW_W-1:0]       m_out_row,
    input  logic [grg_pkg::COL_W-1:0]       m_out_col,
    input  logic                            m_frame_last,
    output int                              fail_count,
    output int                              pending,
    output int                              results_seen,
    output logic                            at_frame_start
);
    import grg_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } reduced_px_t;

    reduced_px_t           expected_px_q[$];
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [HSUM_W-1:0]     line_older [MAX_DST_WIDTH];
    logic [HSUM_W-1:0]     line_mid   [MAX_DST_WIDTH];
    logic [HSUM_W-1:0]     line_new   [MAX_DST_WIDTH];
    logic [PIX_W-1:0]      window     [3];
    int unsigned           col_pos;
    int unsigned           row_pos;

    assign at_frame_start = (col_pos == 0) && (row_pos == 0);

    function automatic int unsigned weigh_taps(input int unsigned oldest, older, old, newest,
                                               input kind_t kind);
        case (kind)
            KIND_FULL:   return oldest + 3 * (older + old) + newest;
            KIND_DOUBLE: return older + 3 * old + 4 * newest;
            default:     return old + 7 * newest;
        endcase
    endfunction

    task automatic reduce_pixel(input logic [PIX_W-1:0] px);
        int unsigned       w, h, x, y, nc, nr, c;
        int unsigned       col_idx [2];
        int unsigned       row_idx [2];
        kind_t             col_kind [2];
        kind_t             row_kind [2];
        logic [HSUM_W-1:0] hsum, t_old, t_mid, t_new;
        logic [PIX_W-1:0]  vals [2][2];
        bit                in_range;
        reduced_px_t       r;

        w = width_reg;
        if (w < SRC_WIDTH_MIN) w = SRC_WIDTH_MIN;
        if (w > MAX_SRC_WIDTH) w = MAX_SRC_WIDTH;
        h = height_reg;
        if (h < SRC_HEIGHT_MIN) h = SRC_HEIGHT_MIN;
        x = (col_pos > w - 1) ? w - 1 : col_pos;
        y = (row_pos > h - 1) ? h - 1 : row_pos;

        nc = 0;
        nr = 0;
        if (x % 2 == 0 && x >= 2) begin
            col_idx[nc] = (x - 2) / 2;
            col_kind[nc] = KIND_FULL;
            nc++;
        end
        if (x == w - 1) begin
            col_idx[nc] = (w - 1) / 2;
            col_kind[nc] = (w % 2 == 0) ? KIND_DOUBLE : KIND_TRIPLE;
            nc++;
        end
        if (y % 2 == 0 && y >= 2) begin
            row_idx[nr] = (y - 2) / 2;
            row_kind[nr] = KIND_FULL;
            nr++;
        end
        if (y == h - 1) begin
            row_idx[nr] = (h - 1) / 2;
            row_kind[nr] = (h % 2 == 0) ? KIND_DOUBLE : KIND_TRIPLE;
            nr++;
        end

        for (int j = 0; j < nc; j++) begin
            c = col_idx[j];
            in_range = c < MAX_DST_WIDTH;
            t_old = in_range ? line_older[c] : '0;
            t_mid = in_range ? line_mid[c] : '0;
            t_new = in_range ? line_new[c] : '0;
            hsum = HSUM_W'(weigh_taps(window[2], window[1], window[0], px, col_kind[j]));
            if (y == 0) begin
                // top edge: replicate the first row into all three lines
                t_old = hsum;
                t_mid = hsum;
                t_new = hsum;
            end else begin
                for (int i = 0; i < nr; i++)
                    vals[i][j] = PIX_W'((weigh_taps(t_old, t_mid, t_new, hsum, row_kind[i])
                                         + ROUND_BIAS) >> ROUND_SHIFT);
                t_old = t_mid;
                t_mid = t_new;
                t_new = hsum;
            end
            if (in_range) begin
                line_older[c] = t_old;
                line_mid[c] = t_mid;
                line_new[c] = t_new;
            end
        end

        if (y != 0) begin
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nc; j++) begin
                    r.value = vals[i][j];
                    r.row = ROW_W'(row_idx[i]);
                    r.col = COL_W'(col_idx[j]);
                    r.last = (y == h - 1) && (x == w - 1) && (i == nr - 1) && (j == nc - 1);
                    expected_px_q.push_back(r);
                end
            end
        end

        if (x == 0) begin
            window[0] = px;
            window[1] = px;
            window[2] = px;
        end else begin
            window[2] = window[1];
            window[1] = window[0];
            window[0] = px;
        end

        if (col_pos >= w - 1) begin
            col_pos = 0;
            if (row_pos >= h - 1)
                row_pos = 0;
            else
                row_pos++;
        end else begin
            col_pos++;
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        reduced_px_t want;
        if (!aresetn) begin
            width_reg = SRC_WIDTH_RESET;
            height_reg = SRC_HEIGHT_RESET;
            for (int i = 0; i < 3; i++)
                window[i] = '0;
            col_pos = 0;
            row_pos = 0;
            expected_px_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SRC_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_SRC_HEIGHT)
                    height_reg = cfg_data;
            end
            if (s_valid && s_ready)
                reduce_pixel(s_pixel);
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_px_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %0d row %0d col %0d last %0d",
                             $time, m_out_value, m_out_row, m_out_col, m_frame_last);
                    fail_count++;
                end else begin
                    want = expected_px_q.pop_front();
                    compare_field("value", want.value, m_out_value);
                    compare_field("row", want.row, m_out_row);
                    compare_field("col", want.col, m_out_col);
                    compare_field("frame_last", want.last, m_frame_last);
                end
            end
        end
        pending = expected_px_q.size();
    end

endmodule

FILE: tb/gray_reduce_4x4_gaussian_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gray_reduce_4x4_gaussian_core_tb
// Streams small gray frames through the reduce core: directed frames at the
// smallest sizes and the register extremes (including out-of-range values and
// geometry changes in the middle of a frame), then random frames. Pixels are
// sent in bursts with random gaps while the result side stalls in its own
// patterns; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module gray_reduce_4x4_gaussian_core_tb;
    import grg_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PIXELS    = 110;
    localparam int RANDOM_RESULTS   = 48;
    localparam int QUIET_CYCLES     = 6;
    localparam int FRAME_PIXELS_MAX = 10000;

    typedef enum logic [1:0] {FILL_ANY, FILL_EDGE, FILL_MAX} fill_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [PIX_W-1:0]       s_pixel;
    logic                   m_valid;
    logic                   m_ready;
    logic [PIX_W-1:0]       m_out_value;
    logic [ROW_W-1:0]       m_out_row;
    logic [COL_W-1:0]       m_out_col;
    logic                   m_frame_last;

    int                     fail_count;
    int                     pending_results;
    int                     results_seen;
    logic                   frame_done;

    int unsigned            cycle_count;
    int unsigned            pixels_sent;
    int unsigned            burst_left;
    int unsigned            stall_mode;
    int unsigned            stall_left;

    gray_reduce_4x4_gaussian_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_last (m_frame_last)
    );

    gray_reduce_4x4_gaussian_checker u_reduce_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel        (s_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_frame_last   (m_frame_last),
        .fail_count     (fail_count),
        .pending        (pending_results),
        .results_seen   (results_seen),
        .at_frame_start (frame_done)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 64);
        end
        stall_left--;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [PIX_W-1:0] next_pixel(input fill_t fill);
        int unsigned pick;
        pick = $urandom_range(0, 7);
        case (fill)
            FILL_MAX:  return 8'hFF;
            FILL_EDGE: return pick[0] ? 8'hFF : 8'h00;
            default: begin
                if (pick == 0)
                    return 8'h00;
                if (pick == 1)
                    return 8'hFF;
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit close);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        if (close)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_SRC_WIDTH, w, 1'b0);
        write_reg(REG_SRC_HEIGHT, h, 1'b1);
    endtask

    // send up to count pixels, stopping early once a frame completes
    task automatic send_run(input int unsigned count, input fill_t fill);
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0) begin
                    if (sent != 0)
                        s_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(negedge aclk);
                end
            end
            burst_left--;
            s_valid <= 1'b1;
            s_pixel <= next_pixel(fill);
            do @(posedge aclk); while (!s_ready);
            @(negedge aclk);
            sent++;
            pixels_sent++;
            if (frame_done)
                break;
        end
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] geom_w;
        logic [CFG_DATA_W-1:0] geom_h;
        int unsigned           random_start;

        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SRC_WIDTH;
        cfg_data = '0;
        s_valid = 1'b0;
        s_pixel = '0;
        m_ready = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // smallest frame, then odd sizes where the last pixel emits a 2x2 block
        set_geometry(12'd3, 12'd2);
        send_run(FRAME_PIXELS_MAX, FILL_EDGE);
        drain_results();
        set_geometry(12'd3, 12'd3);
        send_run(FRAME_PIXELS_MAX, FILL_MAX);
        drain_results();

        // largest sizes, then shrink width and height mid-frame to below range
        set_geometry(12'd4095, 12'd4095);
        send_run(5, FILL_EDGE);
        drain_results();
        write_reg(REG_SRC_WIDTH, 12'd2, 1'b1);
        send_run(4, FILL_ANY);
        drain_results();
        write_reg(REG_SRC_HEIGHT, 12'd1, 1'b1);
        send_run(FRAME_PIXELS_MAX, FILL_ANY);

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS || results_seen < RANDOM_RESULTS) begin
            drain_results();
            geom_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            geom_h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            set_geometry(geom_w, geom_h);
            send_run($urandom_range(1, 48), FILL_ANY);
            if (!frame_done) begin
                drain_results();
                // width may only shrink mid-frame; height may move either way
                if ($urandom_range(0, 1)) begin
                    geom_w = $urandom_range(0, geom_w);
                    write_reg(REG_SRC_WIDTH, geom_w, 1'b1);
                end else begin
                    geom_h = $urandom_range(0, 8);
                    write_reg(REG_SRC_HEIGHT, geom_h, 1'b1);
                end
                send_run(FRAME_PIXELS_MAX, FILL_ANY);
            end
        end

        while (pending_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
